@@ sv/bpt_pkg.sv @@
// Shared types and constants for the byte-pair tree decompressor.
// Depends on nothing; the decompressor unit and the checker refer to it by scoped names.
package bpt_pkg;

    // Longest expansion of one pair code, in bytes
    localparam int MAX_RUN_DEF = 64;

    // Code tables: one entry per byte value
    localparam int TAB_DEPTH = 256;

    // Header type that carries three extra bytes before the length
    localparam logic [15:0] TYPE_EXT = 16'h47fb;

    // Class of a byte code
    typedef enum logic [1:0] {
        CLS_LEAF = 2'd0,
        CLS_ESC  = 2'd1,
        CLS_PAIR = 2'd2
    } cls_t;

    // Header / data parse phase
    typedef enum logic [10:0] {
        PH_TYPE  = 11'b000_0000_0001,
        PH_SKIP  = 11'b000_0000_0010,
        PH_LEN   = 11'b000_0000_0100,
        PH_ESC   = 11'b000_0000_1000,
        PH_COUNT = 11'b000_0001_0000,
        PH_CODE  = 11'b000_0010_0000,
        PH_LEFT  = 11'b000_0100_0000,
        PH_RIGHT = 11'b000_1000_0000,
        PH_DATA  = 11'b001_0000_0000,
        PH_LIT   = 11'b010_0000_0000,
        PH_HALT  = 11'b100_0000_0000
    } phase_t;

    // Input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        run_last;
        logic        stream_done;
        logic [23:0] stored_length;
        logic        overflow;
    } out_word_t;

endpackage

@@ sv/bpt_stream_if.sv @@
// Valid/ready stream channel carrying one word per handshake.
// Payload type is set at instantiation; depends on nothing.
interface bpt_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/bpt_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module bpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/byte_pair_tree_decompressor_unit.sv @@
// Byte-pair tree decompressor: header parser, code tables and pair expander.
// Depends on bpt_pkg, bpt_stream_if and bpt_ram.
// Header bytes and escaped literal are taken in S_IDLE; the literal's word registers at accept.
// Plain byte and escape byte pass through S_DCLS; a plain byte's word registers in the cycle after accept.
// Pair code: classified in S_DCLS, each node below it visited in S_EVAL, each stack pop taken in S_POP,
//   then each buffered byte read in S_ERD and handed out in S_EWR, which waits while the output stalls.
// Overflowed run: a single flagged word after the walk, nothing else emitted.
// Reset (rst_n low, async): header parse restarts, class table reads all plain, no words pending.
module byte_pair_tree_decompressor_unit #(
    parameter int MAX_RUN = bpt_pkg::MAX_RUN_DEF
) (
    input logic          clk,
    input logic          rst_n,
    bpt_stream_if.sink   din,
    bpt_stream_if.source dout
);

    localparam int CNT_W = $clog2(MAX_RUN + 1);
    localparam int IDX_W = $clog2(MAX_RUN);
    localparam int SUM_W = CNT_W + 2;
    localparam int TAB_AW = $clog2(bpt_pkg::TAB_DEPTH);
    localparam logic [CNT_W-1:0] RUN_MAX   = CNT_W'(MAX_RUN);
    localparam logic [SUM_W-1:0] RUN_LIMIT = SUM_W'(MAX_RUN);

    // Sequencer states
    typedef enum logic [5:0] {
        S_IDLE = 6'b00_0001,
        S_DCLS = 6'b00_0010,
        S_EVAL = 6'b00_0100,
        S_POP  = 6'b00_1000,
        S_ERD  = 6'b01_0000,
        S_EWR  = 6'b10_0000
    } seq_t;

    seq_t                 state_reg, state_next;
    bpt_pkg::phase_t      phase_reg, phase_next;
    logic [1:0]           fc_reg, fc_next;
    logic [15:0]          ht_reg, ht_next;
    logic [23:0]          tl_reg, tl_next;
    logic [7:0]           nodes_reg, nodes_next;
    logic [7:0]           code_reg, code_next;
    logic [7:0]           node_reg, node_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     sp_reg, sp_next;
    logic [CNT_W-1:0]     emit_reg, emit_next;
    logic [bpt_pkg::TAB_DEPTH-1:0] valid_reg, valid_next;
    logic                 out_valid_reg, out_valid_next;
    bpt_pkg::out_word_t   out_data_reg, out_data_next;

    // Table RAM ports
    logic                 cls_we, left_we, right_we;
    logic [TAB_AW-1:0]    cls_waddr, child_waddr;
    logic [1:0]           cls_wdata, cls_rdata;
    logic [7:0]           left_rdata, right_rdata;

    // Stack and run buffer ports
    logic                 stk_we, buf_we;
    logic [IDX_W-1:0]     stk_waddr, stk_raddr, buf_waddr, buf_raddr;
    logic [7:0]           stk_rdata, buf_rdata;

    logic                 out_free, acc, ss;
    logic [7:0]           b;
    logic [1:0]           fc_eff;
    logic [15:0]          ht_eff;
    logic [23:0]          tl_eff;
    bpt_pkg::phase_t      ph_eff;
    bpt_pkg::cls_t        cls;
    logic [SUM_W-1:0]     need;
    logic [CNT_W-1:0]     emit_inc;
    logic [CNT_W-1:0]     sp_dec;

    assign out_free   = !out_valid_reg || dout.ready;
    assign din.ready  = (state_reg == S_IDLE) && out_free;
    assign acc        = din.valid && din.ready;
    assign ss         = din.data.stream_start;
    assign b          = din.data.in_byte;
    assign dout.valid = out_valid_reg;
    assign dout.data  = out_data_reg;

    // Stream start restarts the header from this byte
    assign ph_eff = ss ? bpt_pkg::PH_TYPE : phase_reg;
    assign fc_eff = ss ? 2'd0 : fc_reg;
    assign ht_eff = ss ? 16'd0 : ht_reg;
    assign tl_eff = ss ? 24'd0 : tl_reg;

    // Class of the node in hand; entries not written since clear read as plain
    assign cls = valid_reg[node_reg] ? bpt_pkg::cls_t'(cls_rdata) : bpt_pkg::CLS_LEAF;

    assign need      = {2'b00, count_reg} + {2'b00, sp_reg} + SUM_W'(2);
    assign emit_inc  = emit_reg + CNT_W'(1);
    assign sp_dec    = sp_reg - CNT_W'(1);
    assign stk_raddr = sp_dec[IDX_W-1:0];
    assign buf_raddr = emit_reg[IDX_W-1:0];
    assign buf_waddr = count_reg[IDX_W-1:0];

    // Next-state logic
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        fc_next       = fc_reg;
        ht_next       = ht_reg;
        tl_next       = tl_reg;
        nodes_next    = nodes_reg;
        code_next     = code_reg;
        node_next     = node_reg;
        count_next    = count_reg;
        sp_next       = sp_reg;
        emit_next     = emit_reg;
        valid_next    = valid_reg;
        out_data_next = out_data_reg;
        out_valid_next = out_valid_reg && !dout.ready;
        cls_we        = 1'b0;
        cls_waddr     = b;
        cls_wdata     = bpt_pkg::CLS_ESC;
        left_we       = 1'b0;
        right_we      = 1'b0;
        child_waddr   = code_reg;
        stk_we        = 1'b0;
        stk_waddr     = sp_reg[IDX_W-1:0];
        buf_we        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (ss)
                    begin
                        phase_next = bpt_pkg::PH_TYPE;
                        fc_next    = 2'd0;
                        ht_next    = 16'd0;
                        tl_next    = 24'd0;
                        valid_next = '0;
                    end
                    unique case (ph_eff)
                        bpt_pkg::PH_TYPE:
                        begin
                            ht_next = {ht_eff[7:0], b};
                            if (fc_eff == 2'd1)
                            begin
                                fc_next    = 2'd0;
                                phase_next = ({ht_eff[7:0], b} == bpt_pkg::TYPE_EXT)
                                           ? bpt_pkg::PH_SKIP : bpt_pkg::PH_LEN;
                            end
                            else
                            begin
                                fc_next = fc_eff + 2'd1;
                            end
                        end
                        bpt_pkg::PH_SKIP:
                        begin
                            if (fc_eff == 2'd2)
                            begin
                                fc_next    = 2'd0;
                                phase_next = bpt_pkg::PH_LEN;
                            end
                            else
                            begin
                                fc_next = fc_eff + 2'd1;
                            end
                        end
                        bpt_pkg::PH_LEN:
                        begin
                            tl_next = {tl_eff[15:0], b};
                            if (fc_eff == 2'd2)
                            begin
                                fc_next    = 2'd0;
                                phase_next = bpt_pkg::PH_ESC;
                            end
                            else
                            begin
                                fc_next = fc_eff + 2'd1;
                            end
                        end
                        bpt_pkg::PH_ESC:
                        begin
                            cls_we        = 1'b1;
                            cls_waddr     = b;
                            cls_wdata     = bpt_pkg::CLS_ESC;
                            valid_next[b] = 1'b1;
                            phase_next    = bpt_pkg::PH_COUNT;
                        end
                        bpt_pkg::PH_COUNT:
                        begin
                            nodes_next = b;
                            phase_next = (b != 8'd0) ? bpt_pkg::PH_CODE : bpt_pkg::PH_DATA;
                        end
                        bpt_pkg::PH_CODE:
                        begin
                            code_next  = b;
                            phase_next = bpt_pkg::PH_LEFT;
                        end
                        bpt_pkg::PH_LEFT:
                        begin
                            left_we    = 1'b1;
                            phase_next = bpt_pkg::PH_RIGHT;
                        end
                        bpt_pkg::PH_RIGHT:
                        begin
                            right_we             = 1'b1;
                            cls_we               = 1'b1;
                            cls_waddr            = code_reg;
                            cls_wdata            = bpt_pkg::CLS_PAIR;
                            valid_next[code_reg] = 1'b1;
                            nodes_next           = nodes_reg - 8'd1;
                            phase_next = ((nodes_reg - 8'd1) != 8'd0)
                                       ? bpt_pkg::PH_CODE : bpt_pkg::PH_DATA;
                        end
                        bpt_pkg::PH_DATA:
                        begin
                            node_next  = b;
                            state_next = S_DCLS;
                        end
                        bpt_pkg::PH_LIT:
                        begin
                            out_valid_next         = 1'b1;
                            out_data_next          = '0;
                            out_data_next.run_last = 1'b1;
                            if (b != 8'd0)
                            begin
                                out_data_next.out_byte   = b;
                                out_data_next.byte_valid = 1'b1;
                                phase_next = bpt_pkg::PH_DATA;
                            end
                            else
                            begin
                                out_data_next.stream_done   = 1'b1;
                                out_data_next.stored_length = tl_reg;
                                phase_next = bpt_pkg::PH_HALT;
                            end
                        end
                        default:
                        begin
                            // Halted: drop the word
                        end
                    endcase
                end
            end

            // Class of a data byte is ready
            S_DCLS:
            begin
                case (cls)
                    bpt_pkg::CLS_LEAF:
                    begin
                        out_valid_next           = 1'b1;
                        out_data_next            = '0;
                        out_data_next.out_byte   = node_reg;
                        out_data_next.byte_valid = 1'b1;
                        out_data_next.run_last   = 1'b1;
                        state_next               = S_IDLE;
                    end
                    bpt_pkg::CLS_PAIR:
                    begin
                        // Push right child, walk into left child
                        stk_we     = 1'b1;
                        stk_waddr  = '0;
                        sp_next    = CNT_W'(1);
                        count_next = '0;
                        node_next  = left_rdata;
                        state_next = S_EVAL;
                    end
                    default:
                    begin
                        phase_next = bpt_pkg::PH_LIT;
                        state_next = S_IDLE;
                    end
                endcase
            end

            // One step of the depth-first walk
            S_EVAL:
            begin
                if (cls == bpt_pkg::CLS_LEAF)
                begin
                    if (count_reg == RUN_MAX)
                    begin
                        out_valid_next         = 1'b1;
                        out_data_next          = '0;
                        out_data_next.overflow = 1'b1;
                        out_data_next.run_last = 1'b1;
                        phase_next             = bpt_pkg::PH_HALT;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        buf_we     = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (sp_reg == '0)
                        begin
                            emit_next  = '0;
                            state_next = S_ERD;
                        end
                        else
                        begin
                            sp_next    = sp_dec;
                            state_next = S_POP;
                        end
                    end
                end
                else if (need > RUN_LIMIT)
                begin
                    out_valid_next         = 1'b1;
                    out_data_next          = '0;
                    out_data_next.overflow = 1'b1;
                    out_data_next.run_last = 1'b1;
                    phase_next             = bpt_pkg::PH_HALT;
                    state_next             = S_IDLE;
                end
                else
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[IDX_W-1:0];
                    sp_next   = sp_reg + CNT_W'(1);
                    node_next = left_rdata;
                end
            end

            // Popped node is ready
            S_POP:
            begin
                node_next  = stk_rdata;
                state_next = S_EVAL;
            end

            // Run buffer read in flight
            S_ERD:
            begin
                state_next = S_EWR;
            end

            // Hand one buffered byte to the output register
            S_EWR:
            begin
                if (out_free)
                begin
                    out_valid_next           = 1'b1;
                    out_data_next            = '0;
                    out_data_next.out_byte   = buf_rdata;
                    out_data_next.byte_valid = 1'b1;
                    out_data_next.run_last   = (emit_inc == count_reg);
                    emit_next                = emit_inc;
                    state_next = (emit_inc == count_reg) ? S_IDLE : S_ERD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= bpt_pkg::PH_TYPE;
            fc_reg        <= 2'd0;
            ht_reg        <= 16'd0;
            tl_reg        <= 24'd0;
            nodes_reg     <= 8'd0;
            code_reg      <= 8'd0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            fc_reg        <= fc_next;
            ht_reg        <= ht_next;
            tl_reg        <= tl_next;
            nodes_reg     <= nodes_next;
            code_reg      <= code_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and walk registers
    always_ff @(posedge clk)
    begin
        node_reg     <= node_next;
        count_reg    <= count_next;
        sp_reg       <= sp_next;
        emit_reg     <= emit_next;
        out_data_reg <= out_data_next;
    end

    // Code tables, read at the node to be looked at next
    bpt_ram #(.WIDTH(2), .DEPTH(bpt_pkg::TAB_DEPTH)) u_cls_ram (
        .clk   (clk),
        .we    (cls_we),
        .waddr (cls_waddr),
        .wdata (cls_wdata),
        .raddr (node_next),
        .rdata (cls_rdata)
    );

    bpt_ram #(.WIDTH(8), .DEPTH(bpt_pkg::TAB_DEPTH)) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (child_waddr),
        .wdata (b),
        .raddr (node_next),
        .rdata (left_rdata)
    );

    bpt_ram #(.WIDTH(8), .DEPTH(bpt_pkg::TAB_DEPTH)) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (child_waddr),
        .wdata (b),
        .raddr (node_next),
        .rdata (right_rdata)
    );

    // Walk stack of pending right children
    bpt_ram #(.WIDTH(8), .DEPTH(MAX_RUN)) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (right_rdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Run buffer: bytes are held until the walk finishes without overflow
    bpt_ram #(.WIDTH(8), .DEPTH(MAX_RUN)) u_run_ram (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (node_reg),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

endmodule

@@ sv/bpt_checker.sv @@
// Port-level checks for the byte-pair tree decompressor, bound to its top level.
// Depends on bpt_pkg and byte_pair_tree_decompressor_unit.
module bpt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input bpt_pkg::out_word_t out_data
);

    // Output word stays offered until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    // Stalled output word keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("output word changed while stalled");

    // A word is exactly one of: byte, end marker, overflow
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot({out_data.byte_valid, out_data.stream_done,
                               out_data.overflow}))
        else $error("output word kind is not unique");

    // End marker and overflow always close their run
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.stream_done || out_data.overflow) |-> out_data.run_last)
        else $error("terminal word without run_last");

    // Input is taken only when the output slot can accept a word
    a_ready_slot: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!out_valid || out_ready))
        else $error("input ready while output slot blocked");

endmodule

bind byte_pair_tree_decompressor_unit bpt_checker u_bpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (din.ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_data  (dout.data)
);
